/* src/pbft_pkg.sv */
// types and constants shared by the protobuf field tokenizer
package pbft_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef enum logic [1:0] {
    KIND_VARINT  = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [28:0] field_number;
    logic [31:0] value;
    logic        last_of_field;
  } out_item_t;

  typedef enum logic [4:0] {
    PH_TAG     = 5'b00001,
    PH_VALUE   = 5'b00010,
    PH_LENGTH  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_HALT    = 5'b10000
  } phase_e;

  localparam logic [7:0] GROUP_MASK   = 8'h7f;
  localparam logic [7:0] CONT_BIT     = 8'h80;
  localparam logic [2:0] WT_VARINT    = 3'd0;
  localparam logic [2:0] WT_LEN       = 3'd2;
  localparam logic [5:0] GROUP_STEP   = 6'd7;
  localparam logic [5:0] VARINT_LIMIT = 6'd32;

endpackage

/* src/protobuf_field_tokenizer_top.sv */
// top level of the protobuf field tokenizer
// a byte goes through the input register and then the result register to its result
// throughput: one byte per cycle while the result register is free, set by the
// combinational parse step between the input register and the result register
// reset: rst_ni clears the parse state to expecting a tag and empties both registers
module protobuf_field_tokenizer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pbft_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pbft_pkg::out_item_t out_item_o
);
  import pbft_pkg::*;

  logic     stage_valid;
  logic     stage_take;
  in_item_t stage_item;

  pbft_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .stage_valid_o (stage_valid),
    .stage_item_o  (stage_item),
    .stage_take_i  (stage_take)
  );

  pbft_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (stage_valid),
    .item_i       (stage_item),
    .item_take_o  (stage_take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

/* src/pbft_in_stage.sv */
// input register stage of the protobuf field tokenizer
module pbft_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pbft_pkg::in_item_t  in_item_i,
  output logic                stage_valid_o,
  output pbft_pkg::in_item_t  stage_item_o,
  input  logic                stage_take_i
);
  import pbft_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  assign in_ready_o    = !valid_q || stage_take_i;
  assign stage_valid_o = valid_q;
  assign stage_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

/* src/pbft_parser.sv */
// parse state, varint assembly and result register
module pbft_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  pbft_pkg::in_item_t  item_i,
  output logic                item_take_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pbft_pkg::out_item_t out_item_o
);
  import pbft_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] acc_q, acc_d;
  logic [5:0]  bp_q, bp_d;
  logic [28:0] fld_q, fld_d;
  logic [31:0] rem_q, rem_d;
  logic        out_valid_q;
  out_item_t   out_q, out_d;
  logic        emit_d;

  phase_e      ph;
  logic [31:0] acc, rem, acc_new, rem_dec, shifted;
  logic [5:0]  bp, bp_new;
  logic [28:0] fld;
  logic [7:0]  b;
  logic        done, out_free, fire;

  assign out_free    = !out_valid_q || out_ready_i;
  assign fire        = item_valid_i && out_free;
  assign item_take_o = out_free;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    b   = item_i.data_byte;
    ph  = item_i.restart ? PH_TAG : phase_q;
    acc = item_i.restart ? 32'd0 : acc_q;
    bp  = item_i.restart ? 6'd0 : bp_q;
    fld = item_i.restart ? 29'd0 : fld_q;
    rem = item_i.restart ? 32'd0 : rem_q;

    // varint group add, groups from bit 32 upward dropped
    shifted = {24'd0, b & GROUP_MASK} << bp;
    if (bp < VARINT_LIMIT) begin
      acc_new = acc + shifted;
      bp_new  = bp + GROUP_STEP;
    end else begin
      acc_new = acc;
      bp_new  = bp;
    end
    done    = (b & CONT_BIT) == 8'd0;
    rem_dec = (rem != 32'd0) ? rem - 32'd1 : rem;

    phase_d = ph;
    acc_d   = acc;
    bp_d    = bp;
    fld_d   = fld;
    rem_d   = rem;
    emit_d  = 1'b0;
    out_d.kind          = KIND_VARINT;
    out_d.value         = acc_new;
    out_d.last_of_field = 1'b1;

    case (ph)
      PH_TAG: begin
        acc_d = acc_new;
        bp_d  = bp_new;
        if (done) begin
          acc_d = 32'd0;
          bp_d  = 6'd0;
          fld_d = acc_new[31:3];
          if (acc_new[2:0] == WT_VARINT) begin
            phase_d = PH_VALUE;
          end else if (acc_new[2:0] == WT_LEN) begin
            phase_d = PH_LENGTH;
          end else begin
            phase_d     = PH_HALT;
            emit_d      = 1'b1;
            out_d.kind  = KIND_ERROR;
            out_d.value = {29'd0, acc_new[2:0]};
          end
        end
      end
      PH_VALUE: begin
        acc_d = acc_new;
        bp_d  = bp_new;
        if (done) begin
          acc_d   = 32'd0;
          bp_d    = 6'd0;
          phase_d = PH_TAG;
          emit_d  = 1'b1;
        end
      end
      PH_LENGTH: begin
        acc_d = acc_new;
        bp_d  = bp_new;
        if (done) begin
          acc_d               = 32'd0;
          bp_d                = 6'd0;
          rem_d               = acc_new;
          phase_d             = (acc_new == 32'd0) ? PH_TAG : PH_PAYLOAD;
          emit_d              = 1'b1;
          out_d.kind          = KIND_HEADER;
          out_d.last_of_field = acc_new == 32'd0;
        end
      end
      PH_PAYLOAD: begin
        rem_d               = rem_dec;
        emit_d              = 1'b1;
        out_d.kind          = KIND_PAYLOAD;
        out_d.value         = {24'd0, b};
        out_d.last_of_field = rem_dec == 32'd0;
        if (rem_dec == 32'd0) begin
          phase_d = PH_TAG;
        end
      end
      default: begin
        phase_d = PH_HALT;
      end
    endcase
    out_d.field_number = fld_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TAG;
      acc_q       <= 32'd0;
      bp_q        <= 6'd0;
      fld_q       <= 29'd0;
      rem_q       <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        bp_q    <= bp_d;
        fld_q   <= fld_d;
        rem_q   <= rem_d;
      end
      if (out_free) begin
        out_valid_q <= fire && emit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit_d) begin
      out_q <= out_d;
    end
  end

endmodule
